// File: hw/rtl/stt_pkg.sv
// Shared types, codes and character classes for the source text tokenizer.
package stt_pkg;

   // Lexer modes
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_STR   = 3'd1;
   localparam logic [2:0] MODE_ESC   = 3'd2;
   localparam logic [2:0] MODE_NUM   = 3'd3;
   localparam logic [2:0] MODE_IDENT = 3'd4;

   // Token kinds
   localparam logic [2:0] KIND_SYM   = 3'd0;
   localparam logic [2:0] KIND_STR   = 3'd1;
   localparam logic [2:0] KIND_NUM   = 3'd2;
   localparam logic [2:0] KIND_IDENT = 3'd3;
   localparam logic [2:0] KIND_EOF   = 3'd4;
   localparam logic [2:0] KIND_ERR   = 3'd5;

   // Characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_R  = 8'h72;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [7:0]  out_byte;
      logic        has_byte;
      logic        token_begin;
      logic        token_close;
      logic [15:0] line_number;
      logic [15:0] column_number;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] line;
      logic [15:0] column;
      logic        finished;
   } stt_state_type;

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, CH_TAB, CH_LF, CH_CR};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_separator(input logic [7:0] b);
      return b inside {8'h20, CH_TAB, CH_LF, CH_CR,
                       8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
                       8'h2C, 8'h3B, 8'h2E, 8'h2D, 8'h3D, 8'h2B,
                       8'h2A, 8'h2F, 8'h25, 8'h26, 8'h5E, 8'h7C,
                       8'h21, 8'h3C, 8'h3E, 8'h3F, 8'h3A, CH_QUOTE,
                       8'h27, 8'h60, CH_BSLASH, 8'h7E, 8'h23, 8'h24,
                       8'h40};
   endfunction

endpackage

// File: hw/rtl/stt_step.sv
// One tokenizer step: next lexer state and up to two result items.
module stt_step #(
   parameter int MAX_NUMBER_DIGITS = 255,
   parameter int DIGIT_W           = 8
) (
   input  stt_pkg::req_type       req,
   input  stt_pkg::stt_state_type state_cur,
   input  logic [DIGIT_W-1:0]     digit_cur,
   output stt_pkg::stt_state_type state_nxt,
   output logic [DIGIT_W-1:0]     digit_nxt,
   output stt_pkg::rsp_type       item0,
   output stt_pkg::rsp_type       item1,
   output logic [1:0]             item_count
);
   import stt_pkg::*;

   logic [7:0] b;
   logic       col_inc;
   logic       new_line;
   rsp_type    base;

   // Result of handling the byte from idle
   logic       i_emit;
   rsp_type    i_item;
   logic [2:0] i_mode;
   logic       i_digit_one;
   logic       i_col;
   logic       i_nl;

   logic [7:0] esc_byte;

   assign b = req.in_byte;

   always_comb begin
      base               = '0;
      base.line_number   = state_cur.line;
      base.column_number = state_cur.column;
   end

   always_comb begin
      i_emit      = 1'b1;
      i_item      = base;
      i_mode      = MODE_IDLE;
      i_digit_one = 1'b0;
      i_col       = 1'b1;
      i_nl        = 1'b0;
      if (is_space(b)) begin
         i_emit = 1'b0;
         if (b == CH_LF) begin
            i_nl  = 1'b1;
            i_col = 1'b0;
         end
      end else if (b == CH_QUOTE) begin
         i_item.token_kind  = KIND_STR;
         i_item.token_begin = 1'b1;
         i_mode             = MODE_STR;
      end else if (is_separator(b)) begin
         i_item.token_kind  = KIND_SYM;
         i_item.out_byte    = b;
         i_item.has_byte    = 1'b1;
         i_item.token_begin = 1'b1;
         i_item.token_close = 1'b1;
      end else if (is_digit(b)) begin
         i_item.token_kind  = KIND_NUM;
         i_item.out_byte    = b;
         i_item.has_byte    = 1'b1;
         i_item.token_begin = 1'b1;
         i_mode             = MODE_NUM;
         i_digit_one        = 1'b1;
      end else begin
         i_item.token_kind  = KIND_IDENT;
         i_item.out_byte    = b;
         i_item.has_byte    = 1'b1;
         i_item.token_begin = 1'b1;
         i_mode             = MODE_IDENT;
      end
   end

   always_comb begin
      case (b)
         CH_LOW_N: esc_byte = CH_LF;
         CH_LOW_T: esc_byte = CH_TAB;
         CH_LOW_R: esc_byte = CH_CR;
         default:  esc_byte = b;
      endcase
   end

   always_comb begin
      item0              = base;
      item1              = base;
      item_count         = 2'd0;
      state_nxt          = state_cur;
      digit_nxt          = digit_cur;
      col_inc            = 1'b0;
      new_line           = 1'b0;
      if (state_cur.finished) begin
         item0.token_kind = KIND_EOF;
         item_count       = 2'd1;
      end else if (req.end_of_input) begin
         item1.token_kind   = KIND_EOF;
         item_count         = 2'd2;
         case (state_cur.mode)
            MODE_STR: begin
               item0.token_kind  = KIND_STR;
               item0.token_close = 1'b1;
            end
            MODE_ESC: item0.token_kind = KIND_ERR;
            MODE_NUM: begin
               item0.token_kind  = KIND_NUM;
               item0.token_close = 1'b1;
            end
            MODE_IDENT: begin
               item0.token_kind  = KIND_IDENT;
               item0.token_close = 1'b1;
            end
            default: begin
               item0.token_kind = KIND_EOF;
               item_count       = 2'd1;
            end
         endcase
         state_nxt.mode     = MODE_IDLE;
         state_nxt.finished = 1'b1;
         digit_nxt          = '0;
      end else begin
         case (state_cur.mode)
            MODE_STR: begin
               item0.token_kind = KIND_STR;
               if (b == CH_QUOTE) begin
                  item0.token_close = 1'b1;
                  item_count        = 2'd1;
                  state_nxt.mode    = MODE_IDLE;
                  col_inc           = 1'b1;
               end else if (b == CH_BSLASH) begin
                  state_nxt.mode = MODE_ESC;
                  col_inc        = 1'b1;
               end else if (b == CH_LF) begin
                  new_line = 1'b1;
               end else begin
                  item0.out_byte = b;
                  item0.has_byte = 1'b1;
                  item_count     = 2'd1;
                  col_inc        = 1'b1;
               end
            end
            MODE_ESC: begin
               item0.token_kind = KIND_STR;
               item0.out_byte   = esc_byte;
               item0.has_byte   = 1'b1;
               item_count       = 2'd1;
               state_nxt.mode   = MODE_STR;
               col_inc          = 1'b1;
            end
            MODE_NUM: begin
               item0.token_kind = KIND_NUM;
               if (is_digit(b) && (digit_cur < DIGIT_W'(MAX_NUMBER_DIGITS))) begin
                  item0.out_byte = b;
                  item0.has_byte = 1'b1;
                  item_count     = 2'd1;
                  digit_nxt      = digit_cur + DIGIT_W'(1);
                  col_inc        = 1'b1;
               end else begin
                  // close the number, then treat the byte as if idle
                  item0.token_close = 1'b1;
                  item1             = i_item;
                  item_count        = i_emit ? 2'd2 : 2'd1;
                  state_nxt.mode    = i_mode;
                  digit_nxt         = i_digit_one ? DIGIT_W'(1) : '0;
                  col_inc           = i_col;
                  new_line          = i_nl;
               end
            end
            MODE_IDENT: begin
               item0.token_kind = KIND_IDENT;
               if (!is_separator(b)) begin
                  item0.out_byte = b;
                  item0.has_byte = 1'b1;
                  item_count     = 2'd1;
                  col_inc        = 1'b1;
               end else begin
                  item0.token_close = 1'b1;
                  item1             = i_item;
                  item_count        = i_emit ? 2'd2 : 2'd1;
                  state_nxt.mode    = i_mode;
                  digit_nxt         = i_digit_one ? DIGIT_W'(1) : digit_cur;
                  col_inc           = i_col;
                  new_line          = i_nl;
               end
            end
            default: begin
               item0          = i_item;
               item_count     = i_emit ? 2'd1 : 2'd0;
               state_nxt.mode = i_mode;
               digit_nxt      = i_digit_one ? DIGIT_W'(1) : digit_cur;
               col_inc        = i_col;
               new_line       = i_nl;
            end
         endcase
      end

      if (item_count == 2'd1) begin
         item0.last_of_run = 1'b1;
      end
      if (item_count == 2'd2) begin
         item1.last_of_run = 1'b1;
      end

      if (new_line) begin
         if (state_cur.line != COUNT_MAX) begin
            state_nxt.line = state_cur.line + 16'd1;
         end
         state_nxt.column = '0;
      end else if (col_inc && (state_cur.column != COUNT_MAX)) begin
         state_nxt.column = state_cur.column + 16'd1;
      end
   end

endmodule

// File: hw/rtl/source_text_tokenizer.sv
// Source text tokenizer: one source byte per request, token characters out.
// Each accepted request is held in the input stage, lexed from there, and its results
//   are written to the result queue, from which they can be taken.
// Throughput: one request per cycle while each yields at most one result and results
//   are taken; the single-item result port sets the rate when a request yields two results.
// Reset (synchronous, active high): lexer idle, counts and digit count zero,
//   end-of-input flag clear, input stage and result queue empty.
module source_text_tokenizer #(
   parameter int MAX_NUMBER_DIGITS = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stt_pkg::rsp_type rsp_data
);
   import stt_pkg::*;

   localparam int DIGIT_W = $clog2(MAX_NUMBER_DIGITS + 1);
   // Result queue: 4 entries, room for two results per lexed request
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = 2;

   // Input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    req_accept;
   logic    fire;

   // Lexer state
   stt_state_type      state_ff, state_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;

   // Step outputs
   rsp_type    item0, item1;
   logic [1:0] item_count;
   logic [1:0] push_count;

   // Result queue
   rsp_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             pop;

   // A request is lexed once the queue can take two results
   assign fire       = in_valid_ff && (count_ff <= (PTR_W + 1)'(QUEUE_DEPTH - 2));
   assign req_ready  = !in_valid_ff || fire;
   assign req_accept = req_valid && req_ready;
   assign in_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   stt_step #(
      .MAX_NUMBER_DIGITS (MAX_NUMBER_DIGITS),
      .DIGIT_W           (DIGIT_W)
   ) u_step (
      .req        (in_data_ff),
      .state_cur  (state_ff),
      .digit_cur  (digit_ff),
      .state_nxt  (state_in),
      .digit_nxt  (digit_in),
      .item0      (item0),
      .item1      (item1),
      .item_count (item_count)
   );

   assign push_count = fire ? item_count : 2'd0;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = queue_ff[rd_ptr_ff];
   assign pop        = rsp_valid && rsp_ready;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + (PTR_W + 1)'(push_count) - (PTR_W + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{mode: MODE_IDLE, line: '0, column: '0, finished: 1'b0};
         digit_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            state_ff <= state_in;
            digit_ff <= digit_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= item0;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= item1;
      end
   end

   // Queue occupancy never goes beyond its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W + 1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // Pointer distance agrees with the occupancy count
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == (PTR_W + 1)'(QUEUE_DEPTH)) ||
      ((wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0]))
      else $error("queue pointers and count disagree");

   // Once end of input is seen, the lexer stays finished
   assert property (@(posedge clock) disable iff (reset)
      state_ff.finished |=> state_ff.finished)
      else $error("finished flag dropped");

   // After end of input each request gives exactly one eof result
   assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff.finished) |->
      (item_count == 2'd1) && (item0.token_kind == KIND_EOF) && item0.last_of_run)
      else $error("request after end of input did not give a single eof");

endmodule

// File: tb/source_text_tokenizer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for source_text_tokenizer: directed and random source text.
module source_text_tokenizer_test;
   import stt_pkg::*;

   localparam int MAX_DIGITS   = 255;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 460;      // directed + random requests before the full-speed tail
   localparam int CHOKE_AFTER  = 60;       // accepted requests before the long result stall
   localparam int CHOKE_CYCLES = 300;
   localparam int TAIL_RUN     = 10;       // back-to-back blanks, then newlines, at full speed
   localparam int DRAIN_CYCLES = 16;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // One pending request plus the pacing marks that ride with it.
   typedef struct {
      req_type data;
      bit      drain;    // hold this request until every expected token is back
      bit      calm;     // from this request on, neither side idles
   } feed_item;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   feed_item source_feed[$];     // requests still to be offered
   rsp_type  token_queue[$];     // tokens the lexer is expected to emit, oldest first
   rsp_type  step_tokens[$];     // tokens produced by the request being lexed

   bit drain_mark = 1'b0;
   bit calm_mark  = 1'b0;
   bit idle_on    = 1'b1;
   int fed_total;
   int accepted_count = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   // Lexer state mirrored by the predictor, at its reset values.
   logic [2:0]  mode_q     = MODE_IDLE;
   logic [7:0]  digit_q    = 8'd0;
   logic [15:0] line_q     = 16'd0;
   logic [15:0] col_q      = 16'd0;
   bit          finished_q = 1'b0;

   source_text_tokenizer #(
      .MAX_NUMBER_DIGITS(MAX_DIGITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Character classes
   // ------------------------------------------------------------------
   function automatic bit is_blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
   endfunction

   function automatic bit is_digit_char(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   // Bytes that end an identifier: blanks plus punctuation.
   function automatic bit ends_word(logic [7:0] b);
      case (b)
         CH_SPACE, CH_TAB, CH_LF, CH_CR, "(", ")", "{", "}", "[", "]", ",", ";", ".",
         "-", "=", "+", "*", "/", "%", "&", "^", "|", "!", "<", ">", "?", ":",
         CH_QUOTE, "'", 8'h60, CH_BSLASH, "~", "#", "$", "@": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------
   // Tokens carry the position as it stands when they are emitted, so every
   // caller emits first and advances the counts afterward.
   function automatic void add_token(logic [2:0] kind, logic [7:0] b, bit has,
                                     bit opens, bit closes);
      rsp_type t;
      t.token_kind    = kind;
      t.out_byte      = has ? b : 8'h00;
      t.has_byte      = has;
      t.token_begin   = opens;
      t.token_close   = closes;
      t.line_number   = line_q;
      t.column_number = col_q;
      t.last_of_run   = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void bump_column();
      if (col_q != COUNT_MAX) col_q = col_q + 16'd1;
   endfunction

   function automatic void next_line();
      if (line_q != COUNT_MAX) line_q = line_q + 16'd1;
      col_q = 16'd0;
   endfunction

   // A byte met between tokens: skip blanks, or open a token of its class.
   function automatic void open_token(logic [7:0] b);
      if (is_blank(b)) begin
         if (b == CH_LF) next_line();
         else bump_column();
      end else if (b == CH_QUOTE) begin
         add_token(KIND_STR, 8'h00, 1'b0, 1'b1, 1'b0);
         mode_q = MODE_STR;
         bump_column();
      end else if (ends_word(b)) begin
         add_token(KIND_SYM, b, 1'b1, 1'b1, 1'b1);
         bump_column();
      end else if (is_digit_char(b)) begin
         add_token(KIND_NUM, b, 1'b1, 1'b1, 1'b0);
         mode_q  = MODE_NUM;
         digit_q = 8'd1;
         bump_column();
      end else begin
         add_token(KIND_IDENT, b, 1'b1, 1'b1, 1'b0);
         mode_q = MODE_IDENT;
         bump_column();
      end
   endfunction

   // Lex one accepted request and queue the tokens it must produce.
   function automatic void lex_request(req_type r);
      logic [7:0] b;
      logic [7:0] d;
      b = r.in_byte;
      step_tokens.delete();
      if (finished_q) begin
         add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
      end else if (r.end_of_input) begin
         // close whatever is open, then the eof token
         case (mode_q)
            MODE_STR:   add_token(KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1);
            MODE_ESC:   add_token(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0);
            MODE_NUM:   add_token(KIND_NUM, 8'h00, 1'b0, 1'b0, 1'b1);
            MODE_IDENT: add_token(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1);
            default: ;
         endcase
         add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
         mode_q     = MODE_IDLE;
         digit_q    = 8'd0;
         finished_q = 1'b1;
      end else begin
         case (mode_q)
            MODE_STR: begin
               if (b == CH_QUOTE) begin
                  add_token(KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1);
                  mode_q = MODE_IDLE;
                  bump_column();
               end else if (b == CH_BSLASH) begin
                  mode_q = MODE_ESC;
                  bump_column();
               end else if (b == CH_LF) begin
                  next_line();          // raw newline in a string is dropped
               end else begin
                  add_token(KIND_STR, b, 1'b1, 1'b0, 1'b0);
                  bump_column();
               end
            end
            MODE_ESC: begin
               // unknown escapes, escaped LF included, pass the byte through
               d = b;
               if (b == CH_LOW_N) d = CH_LF;
               else if (b == CH_LOW_T) d = CH_TAB;
               else if (b == CH_LOW_R) d = CH_CR;
               add_token(KIND_STR, d, 1'b1, 1'b0, 1'b0);
               mode_q = MODE_STR;
               bump_column();
            end
            MODE_NUM: begin
               if (is_digit_char(b) && digit_q < MAX_DIGITS) begin
                  add_token(KIND_NUM, b, 1'b1, 1'b0, 1'b0);
                  digit_q = digit_q + 8'd1;
                  bump_column();
               end else begin
                  // non-digit or digit limit: close, then relex the byte
                  add_token(KIND_NUM, 8'h00, 1'b0, 1'b0, 1'b1);
                  mode_q  = MODE_IDLE;
                  digit_q = 8'd0;
                  open_token(b);
               end
            end
            MODE_IDENT: begin
               if (!ends_word(b)) begin
                  add_token(KIND_IDENT, b, 1'b1, 1'b0, 1'b0);
                  bump_column();
               end else begin
                  add_token(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1);
                  mode_q = MODE_IDLE;
                  open_token(b);
               end
            end
            default: begin
               mode_q = MODE_IDLE;
               open_token(b);
            end
         endcase
      end
      if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------
   function automatic void feed(logic [7:0] b, bit eoi = 1'b0);
      feed_item f;
      f.data.in_byte      = b;
      f.data.end_of_input = eoi;
      f.drain             = drain_mark;
      f.calm              = calm_mark;
      drain_mark          = 1'b0;
      calm_mark           = 1'b0;
      source_feed.push_back(f);
   endfunction

   // Identifier byte; a first byte must not be a digit either.
   function automatic logic [7:0] word_char(bit first);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (ends_word(b) || (first && is_digit_char(b)));
      return b;
   endfunction

   function automatic logic [7:0] symbol_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (!ends_word(b) || is_blank(b) || b == CH_QUOTE);
      return b;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] escape_char();
      case ($urandom_range(0, 6))
         0: return CH_LOW_N;
         1: return CH_LOW_T;
         2: return CH_LOW_R;
         3: return CH_BSLASH;
         4: return CH_QUOTE;
         5: return CH_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] digit_char();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   // Mostly well-formed tokens with random content, some noise and stray quotes.
   function automatic void add_chunk();
      logic [7:0] b;
      case ($urandom_range(0, 11))
         0, 1: begin
            feed(word_char(1'b1));
            repeat ($urandom_range(0, 6)) feed(word_char(1'b0));
         end
         2, 3: repeat ($urandom_range(1, 6)) feed(digit_char());
         4, 5: begin
            feed(CH_QUOTE);
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 7))
                  0: feed(CH_LF);
                  1, 2: begin
                     feed(CH_BSLASH);
                     feed(escape_char());
                  end
                  default: begin
                     do b = 8'($urandom_range(0, 255));
                     while (b == CH_QUOTE || b == CH_BSLASH);
                     feed(b);
                  end
               endcase
            end
            feed(CH_QUOTE);
         end
         6, 7: feed(symbol_char());
         8, 9: repeat ($urandom_range(1, 3)) feed(blank_char());
         10: feed(8'($urandom_range(0, 255)));
         default: feed(CH_QUOTE);      // unbalanced quote swallows what follows
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offers queued requests, predicts each accepted one
   // ------------------------------------------------------------------
   int gap_left = 0;

   always @(posedge clock) begin : drive_requests
      feed_item item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            lex_request(req_data);
            accepted_count <= accepted_count + 1;
         end
         // Only pick the next request once the current one is gone, so valid
         // and payload stay put while the block stalls.
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (source_feed.size() == 0 ||
                         (source_feed[0].drain && token_queue.size() != 0)) begin
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
               gap_left  <= $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else begin
               item      = source_feed.pop_front();
               req_valid <= 1'b1;
               req_data  <= item.data;
               if (item.calm) idle_on <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Token monitor: checks every accepted token against the oldest prediction
   // ------------------------------------------------------------------
   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   int  stall_left = 0;
   int  hold_left  = 0;
   bit  choke_done = 1'b0;

   always @(posedge clock) begin : check_tokens
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (token_queue.size() == 0) begin
               $display("%0t: unexpected token, expected none, got %h", $time, rsp_data);
               error_count++;
            end else begin
               want = token_queue.pop_front();
               compare_field("token_kind", want.token_kind, rsp_data.token_kind);
               compare_field("out_byte", want.out_byte, rsp_data.out_byte);
               compare_field("has_byte", want.has_byte, rsp_data.has_byte);
               compare_field("token_begin", want.token_begin, rsp_data.token_begin);
               compare_field("token_close", want.token_close, rsp_data.token_close);
               compare_field("line_number", want.line_number, rsp_data.line_number);
               compare_field("column_number", want.column_number, rsp_data.column_number);
               compare_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            end
         end
         // One long hold early on lets the block back up into its input side.
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!choke_done && accepted_count >= CHOKE_AFTER) begin
            choke_done <= 1'b1;
            hold_left  <= CHOKE_CYCLES - 1;
            rsp_ready  <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 17);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("source_text_tokenizer verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request sequence, reset and end of run
   // ------------------------------------------------------------------
   initial begin : run_test
      bit long_done;
      long_done = 1'b0;

      // Directed: every token class, blanks, raw and escaped newlines in a
      // string, an unknown escape, an escaped quote, extreme bytes as
      // identifier text, a number cut short by a letter.
      feed("x"); feed("9"); feed(CH_SPACE); feed("4"); feed("2"); feed("(");
      feed(CH_TAB); feed(CH_CR); feed(CH_LF);
      feed(CH_QUOTE); feed("a"); feed(CH_LF); feed(CH_BSLASH); feed(CH_LOW_T);
      feed(CH_BSLASH); feed("q"); feed(CH_BSLASH); feed(CH_LF);
      feed(CH_BSLASH); feed(CH_QUOTE); feed(CH_QUOTE);
      feed(8'h00); feed(8'hFF); feed("-"); feed("7"); feed("a"); feed("@");

      // Random text; the first random request waits for the directed tokens.
      drain_mark = 1'b1;
      while (source_feed.size() < RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0) drain_mark = 1'b1;
         add_chunk();
         if (!long_done && source_feed.size() > RANDOM_ITEMS / 2) begin
            // digit limit: a full number, then the next digits open another
            long_done = 1'b1;
            feed(CH_SPACE);
            repeat (MAX_DIGITS + 2) feed(digit_char());
            feed(CH_SPACE);
         end
      end

      // Full speed from here: runs of blanks and newlines around short tokens.
      calm_mark = 1'b1;
      feed(CH_SPACE);
      repeat (TAIL_RUN) feed(CH_SPACE);
      feed("a"); feed("b"); feed(";"); feed(CH_QUOTE); feed("c"); feed(CH_QUOTE);
      feed(CH_LF);
      repeat (TAIL_RUN) feed(CH_LF);
      feed("9"); feed(CH_SPACE); feed(CH_QUOTE); feed(CH_LF); feed("d"); feed(CH_QUOTE);

      // End of input from a random lexer state, then a few requests after eof.
      case ($urandom_range(0, 4))
         0: ;
         1: begin feed(CH_QUOTE); feed("z"); end
         2: begin feed(CH_QUOTE); feed(CH_BSLASH); end
         3: feed("5");
         default: feed("q");
      endcase
      feed(8'($urandom_range(0, 255)), 1'b1);
      feed(8'($urandom_range(0, 255)), 1'b0);
      feed(8'($urandom_range(0, 255)), 1'b1);
      feed(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      fed_total = source_feed.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != fed_total) @(posedge clock);
      while (token_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (token_queue.size() != 0) begin
         $display("%0t: %0d expected tokens never arrived", $time, token_queue.size());
         error_count++;
      end

      if (error_count == 0)
         $display("source_text_tokenizer verification clean");
      else
         $display("source_text_tokenizer verification failed");
      $finish;
   end

endmodule
